[rtl/media_presentation_clock_defines.svh]
// assertion macros shared by the checker
`ifndef MEDIA_PRESENTATION_CLOCK_DEFINES_SVH
`define MEDIA_PRESENTATION_CLOCK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpc: same-cycle check failed");

// next-cycle implication, checked outside reset
`define MPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpc: next-cycle check failed");

`endif

[rtl/mpc_pkg.sv]
package mpc_pkg;

    // default parameter values
    localparam int unsigned POSITION_BITS_DEF      = 48;
    localparam int unsigned RATE_FRACTION_BITS_DEF = 16;

    // fixed field widths
    localparam int unsigned POS_W       = 48;
    localparam int unsigned RATE_W      = 20;
    localparam int unsigned CMD_W       = 3;
    localparam int unsigned LATENCY_W   = 21;
    localparam int unsigned THRESHOLD_W = 24;
    localparam int unsigned TICK_W      = 10;
    localparam int unsigned CFG_ADDR_W  = 4;
    localparam int unsigned CFG_DATA_W  = 32;

    // register reset values
    localparam logic [THRESHOLD_W-1:0] JUMP_THRESHOLD_RST = THRESHOLD_W'(500000);
    localparam logic [TICK_W-1:0]      TICK_RST           = TICK_W'(1);

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_UPDATE    = 3'd1,
        CMD_PAUSE_SET = 3'd2,
        CMD_SET_RATE  = 3'd3,
        CMD_SEEK      = 3'd4,
        CMD_RESET     = 3'd5
    } cmd_t;

    // register indexes
    typedef enum logic [1:0] {
        REG_OUTPUT_LATENCY = 2'd0,
        REG_SINK_LATENCY   = 2'd1,
        REG_JUMP_THRESHOLD = 2'd2,
        REG_TICK           = 2'd3
    } cfg_reg_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [LATENCY_W-1:0]   output_latency;
        logic [LATENCY_W-1:0]   sink_latency;
        logic [THRESHOLD_W-1:0] jump_threshold;
        logic [TICK_W-1:0]      tick;
    } cfg_t;

    // one command word as held in the input register
    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [POS_W-1:0] position_value;
        logic                    pause_flag;
        logic [RATE_W-1:0]       new_rate;
    } cmd_word_t;

    // status handed from the clock core to the report stage
    typedef struct packed {
        logic valid;
        logic started;
        logic paused;
        logic reanchored;
    } status_t;

endpackage

[rtl/mpc_cmd_if.sv]
interface mpc_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [mpc_pkg::CMD_W-1:0]             command;
    logic signed [mpc_pkg::POS_W-1:0]      position_value;
    logic                                  pause_flag;
    logic [mpc_pkg::RATE_W-1:0]            new_rate;

    modport source (output valid, output command, output position_value,
                    output pause_flag, output new_rate, input ready);
    modport sink   (input valid, input command, input position_value,
                    input pause_flag, input new_rate, output ready);
endinterface

[rtl/mpc_report_if.sv]
interface mpc_report_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mpc_pkg::POS_W-1:0]      reported_position;
    logic                                  is_started;
    logic                                  is_paused;
    logic [mpc_pkg::RATE_W-1:0]            current_rate;
    logic                                  reanchored;

    modport source (output valid, output reported_position, output is_started,
                    output is_paused, output current_rate, output reanchored,
                    input ready);
    modport sink   (input valid, input reported_position, input is_started,
                    input is_paused, input current_rate, input reanchored,
                    output ready);
endinterface

[rtl/mpc_cfg_regs.sv]
module mpc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [mpc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [mpc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output mpc_pkg::cfg_t                   cfg
);

    logic [mpc_pkg::LATENCY_W-1:0]   output_latency_reg;
    logic [mpc_pkg::LATENCY_W-1:0]   sink_latency_reg;
    logic [mpc_pkg::THRESHOLD_W-1:0] jump_threshold_reg;
    logic [mpc_pkg::TICK_W-1:0]      tick_reg;
    mpc_pkg::cfg_reg_t               reg_sel;
    logic                            wr_en;

    assign reg_sel = mpc_pkg::cfg_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_latency_reg <= '0;
            sink_latency_reg   <= '0;
            jump_threshold_reg <= mpc_pkg::JUMP_THRESHOLD_RST;
            tick_reg           <= mpc_pkg::TICK_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mpc_pkg::REG_OUTPUT_LATENCY:
                    output_latency_reg <= pwdata[mpc_pkg::LATENCY_W-1:0];
                mpc_pkg::REG_SINK_LATENCY:
                    sink_latency_reg <= pwdata[mpc_pkg::LATENCY_W-1:0];
                mpc_pkg::REG_JUMP_THRESHOLD:
                    jump_threshold_reg <= pwdata[mpc_pkg::THRESHOLD_W-1:0];
                mpc_pkg::REG_TICK:
                    tick_reg <= pwdata[mpc_pkg::TICK_W-1:0];
                default:
                    tick_reg <= tick_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            mpc_pkg::REG_OUTPUT_LATENCY: prdata = mpc_pkg::CFG_DATA_W'(output_latency_reg);
            mpc_pkg::REG_SINK_LATENCY:   prdata = mpc_pkg::CFG_DATA_W'(sink_latency_reg);
            mpc_pkg::REG_JUMP_THRESHOLD: prdata = mpc_pkg::CFG_DATA_W'(jump_threshold_reg);
            mpc_pkg::REG_TICK:           prdata = mpc_pkg::CFG_DATA_W'(tick_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.output_latency = output_latency_reg;
    assign cfg.sink_latency   = sink_latency_reg;
    assign cfg.jump_threshold = jump_threshold_reg;
    assign cfg.tick           = tick_reg;

endmodule

[rtl/mpc_scale.sv]
module mpc_scale #(
    parameter int unsigned POSITION_BITS      = mpc_pkg::POSITION_BITS_DEF,
    parameter int unsigned RATE_FRACTION_BITS = mpc_pkg::RATE_FRACTION_BITS_DEF
) (
    input  logic signed [POSITION_BITS-1:0] elapsed,
    input  logic [((RATE_FRACTION_BITS + 1 > mpc_pkg::RATE_W) ?
                   RATE_FRACTION_BITS + 1 : mpc_pkg::RATE_W)-1:0] rate,
    output logic signed [POSITION_BITS-1:0] scaled
);

    localparam int unsigned RATE_BITS = (RATE_FRACTION_BITS + 1 > mpc_pkg::RATE_W) ?
                                        RATE_FRACTION_BITS + 1 : mpc_pkg::RATE_W;
    localparam int unsigned PROD_W    = POSITION_BITS + RATE_BITS;
    localparam logic signed [POSITION_BITS-1:0] POS_MAX =
        {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN =
        {1'b1, {(POSITION_BITS-1){1'b0}}};
    localparam logic [PROD_W-1:0] LIM_POS = PROD_W'(POS_MAX);
    localparam logic [PROD_W-1:0] LIM_NEG = LIM_POS + PROD_W'(1);

    logic                     neg;
    logic [POSITION_BITS-1:0] mag;
    logic [PROD_W-1:0]        product;
    logic [PROD_W-1:0]        shifted;
    logic                     over;

    // magnitude times rate, truncated toward zero
    assign neg     = elapsed[POSITION_BITS-1];
    assign mag     = neg ? (~elapsed + POSITION_BITS'(1)) : elapsed;
    assign product = PROD_W'(mag) * PROD_W'(rate);
    assign shifted = product >> RATE_FRACTION_BITS;

    // saturate to the signed position range
    assign over = neg ? (shifted >= LIM_NEG) : (shifted >= LIM_POS);

    always_comb
    begin
        if (over)
            scaled = neg ? POS_MIN : POS_MAX;
        else if (neg)
            scaled = -shifted[POSITION_BITS-1:0];
        else
            scaled = shifted[POSITION_BITS-1:0];
    end

endmodule

[rtl/mpc_clock_core.sv]
module mpc_clock_core #(
    parameter int unsigned POSITION_BITS      = mpc_pkg::POSITION_BITS_DEF,
    parameter int unsigned RATE_FRACTION_BITS = mpc_pkg::RATE_FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mpc_cmd_if.sink                         cmd_ch,
    input  mpc_pkg::cfg_t                   cfg,
    input  logic                            report_ready,
    output mpc_pkg::status_t                status,
    output logic signed [POSITION_BITS-1:0] clock_pos,
    output logic [mpc_pkg::RATE_W-1:0]      rate
);

    localparam int unsigned RATE_BITS = (RATE_FRACTION_BITS + 1 > mpc_pkg::RATE_W) ?
                                        RATE_FRACTION_BITS + 1 : mpc_pkg::RATE_W;
    localparam logic signed [POSITION_BITS-1:0] POS_MAX =
        {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN =
        {1'b1, {(POSITION_BITS-1){1'b0}}};
    localparam logic signed [64:0] WIDE_MAX = 65'(POS_MAX);
    localparam logic signed [64:0] WIDE_MIN = 65'(POS_MIN);
    localparam logic [RATE_BITS-1:0] RATE_ONE = RATE_BITS'(1) << RATE_FRACTION_BITS;

    // input register
    logic                   cmd_valid_reg;
    mpc_pkg::cmd_word_t     cmd_word_reg;

    // clock state
    logic signed [POSITION_BITS-1:0] anchor_reg, anchor_next;
    logic signed [POSITION_BITS-1:0] elapsed_reg, elapsed_next;
    logic [RATE_BITS-1:0]            rate_reg, rate_next;
    logic                            started_reg, started_next;
    logic                            paused_reg, paused_next;
    logic                            done_valid_reg;
    logic                            reanch_reg, reanch_next;

    logic                            cmd_adv;
    logic                            done_free;
    logic signed [POSITION_BITS-1:0] scaled;
    logic signed [POSITION_BITS-1:0] fold_pos;
    logic signed [POSITION_BITS-1:0] now_pos;
    logic signed [POSITION_BITS-1:0] req_pos;
    logic signed [POSITION_BITS-1:0] diff;
    logic signed [POSITION_BITS-1:0] tick_sum;
    logic signed [POSITION_BITS-1:0] neg_latency;
    logic signed [64:0]              wide_pos;
    logic                            jump;
    mpc_pkg::cmd_t                   cmd;

    function automatic logic signed [POSITION_BITS-1:0] sat_add(
        input logic signed [POSITION_BITS-1:0] a,
        input logic signed [POSITION_BITS-1:0] b
    );
        logic signed [POSITION_BITS:0] s;
        s = (POSITION_BITS+1)'(a) + (POSITION_BITS+1)'(b);
        if (s[POSITION_BITS] != s[POSITION_BITS-1])
            sat_add = s[POSITION_BITS] ? POS_MIN : POS_MAX;
        else
            sat_add = s[POSITION_BITS-1:0];
    endfunction

    function automatic logic signed [POSITION_BITS-1:0] sat_sub(
        input logic signed [POSITION_BITS-1:0] a,
        input logic signed [POSITION_BITS-1:0] b
    );
        logic signed [POSITION_BITS:0] s;
        s = (POSITION_BITS+1)'(a) - (POSITION_BITS+1)'(b);
        if (s[POSITION_BITS] != s[POSITION_BITS-1])
            sat_sub = s[POSITION_BITS] ? POS_MIN : POS_MAX;
        else
            sat_sub = s[POSITION_BITS-1:0];
    endfunction

    // handshake through the input register and the state stage
    assign done_free    = !done_valid_reg || report_ready;
    assign cmd_adv      = cmd_valid_reg && done_free;
    assign cmd_ch.ready = !cmd_valid_reg || cmd_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= (cmd_ch.valid && cmd_ch.ready) || (cmd_valid_reg && !cmd_adv);
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            cmd_word_reg.command        <= cmd_ch.command;
            cmd_word_reg.position_value <= cmd_ch.position_value;
            cmd_word_reg.pause_flag     <= cmd_ch.pause_flag;
            cmd_word_reg.new_rate       <= cmd_ch.new_rate;
        end
    end

    // scaled elapsed time and the clock position of the current state
    mpc_scale #(
        .POSITION_BITS      (POSITION_BITS),
        .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
    ) u_scale (
        .elapsed (elapsed_reg),
        .rate    (rate_reg),
        .scaled  (scaled)
    );

    assign fold_pos = sat_add(anchor_reg, scaled);
    assign now_pos  = (started_reg && !paused_reg) ? fold_pos : anchor_reg;

    // requested position clamped to the position range
    assign wide_pos = 65'(cmd_word_reg.position_value);
    always_comb
    begin
        if (wide_pos > WIDE_MAX)
            req_pos = POS_MAX;
        else if (wide_pos < WIDE_MIN)
            req_pos = POS_MIN;
        else
            req_pos = wide_pos[POSITION_BITS-1:0];
    end

    assign diff        = sat_sub(req_pos, now_pos);
    assign jump        = diff > $signed(POSITION_BITS'(cfg.jump_threshold));
    assign tick_sum    = sat_add(elapsed_reg, $signed(POSITION_BITS'(cfg.tick)));
    assign neg_latency = -$signed(POSITION_BITS'(cfg.output_latency));
    assign cmd         = mpc_pkg::cmd_t'(cmd_word_reg.command);

    // next state per command
    always_comb
    begin
        anchor_next  = anchor_reg;
        elapsed_next = elapsed_reg;
        rate_next    = rate_reg;
        started_next = started_reg;
        paused_next  = paused_reg;
        reanch_next  = 1'b0;
        unique case (cmd)
            mpc_pkg::CMD_TICK:
            begin
                elapsed_next = tick_sum;
            end
            mpc_pkg::CMD_UPDATE:
            begin
                if (!started_reg)
                begin
                    anchor_next  = req_pos;
                    elapsed_next = neg_latency;
                    started_next = 1'b1;
                end
                else if (jump)
                begin
                    anchor_next  = req_pos;
                    elapsed_next = '0;
                    reanch_next  = 1'b1;
                end
            end
            mpc_pkg::CMD_PAUSE_SET:
            begin
                if (cmd_word_reg.pause_flag != paused_reg)
                begin
                    if (started_reg)
                    begin
                        if (cmd_word_reg.pause_flag)
                            anchor_next = fold_pos;
                        elapsed_next = '0;
                    end
                    paused_next = cmd_word_reg.pause_flag;
                end
            end
            mpc_pkg::CMD_SET_RATE:
            begin
                if (started_reg && !paused_reg)
                begin
                    anchor_next  = fold_pos;
                    elapsed_next = '0;
                end
                rate_next = RATE_BITS'(cmd_word_reg.new_rate);
            end
            mpc_pkg::CMD_SEEK:
            begin
                anchor_next  = req_pos;
                elapsed_next = neg_latency;
                started_next = 1'b1;
            end
            mpc_pkg::CMD_RESET:
            begin
                anchor_next  = '0;
                elapsed_next = '0;
                rate_next    = RATE_ONE;
                started_next = 1'b0;
                paused_next  = 1'b0;
            end
            default:
            begin
                reanch_next = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg     <= '0;
            elapsed_reg    <= '0;
            rate_reg       <= RATE_ONE;
            started_reg    <= 1'b0;
            paused_reg     <= 1'b0;
            reanch_reg     <= 1'b0;
            done_valid_reg <= 1'b0;
        end
        else
        begin
            done_valid_reg <= cmd_adv || (done_valid_reg && !report_ready);
            if (cmd_adv)
            begin
                anchor_reg  <= anchor_next;
                elapsed_reg <= elapsed_next;
                rate_reg    <= rate_next;
                started_reg <= started_next;
                paused_reg  <= paused_next;
                reanch_reg  <= reanch_next;
            end
        end
    end

    assign status.valid      = done_valid_reg;
    assign status.started    = started_reg;
    assign status.paused     = paused_reg;
    assign status.reanchored = reanch_reg;
    assign clock_pos         = now_pos;
    assign rate              = rate_reg[mpc_pkg::RATE_W-1:0];

endmodule

[rtl/mpc_report.sv]
module mpc_report #(
    parameter int unsigned POSITION_BITS = mpc_pkg::POSITION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mpc_pkg::status_t                status,
    input  logic signed [POSITION_BITS-1:0] clock_pos,
    input  logic [mpc_pkg::RATE_W-1:0]      rate,
    input  logic [mpc_pkg::LATENCY_W-1:0]   sink_latency,
    output logic                            ready,
    mpc_report_if.source                    report_ch
);

    localparam logic signed [POSITION_BITS-1:0] POS_MAX =
        {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN =
        {1'b1, {(POSITION_BITS-1){1'b0}}};

    logic                               valid_reg;
    logic signed [mpc_pkg::POS_W-1:0]   pos_reg;
    logic                               started_reg;
    logic                               paused_reg;
    logic [mpc_pkg::RATE_W-1:0]         rate_reg;
    logic                               reanch_reg;
    logic signed [POSITION_BITS:0]      diff_wide;
    logic signed [POSITION_BITS-1:0]    rep_pos;
    logic                               load;

    // position minus hidden sink latency, saturated
    assign diff_wide = (POSITION_BITS+1)'(clock_pos)
                     - (POSITION_BITS+1)'(sink_latency);
    always_comb
    begin
        if (diff_wide[POSITION_BITS] != diff_wide[POSITION_BITS-1])
            rep_pos = diff_wide[POSITION_BITS] ? POS_MIN : POS_MAX;
        else
            rep_pos = diff_wide[POSITION_BITS-1:0];
    end

    // output register
    assign ready = !valid_reg || report_ch.ready;
    assign load  = status.valid && ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= load || (valid_reg && !report_ch.ready);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg     <= mpc_pkg::POS_W'(rep_pos);
            started_reg <= status.started;
            paused_reg  <= status.paused;
            rate_reg    <= rate;
            reanch_reg  <= status.reanchored;
        end
    end

    assign report_ch.valid             = valid_reg;
    assign report_ch.reported_position = pos_reg;
    assign report_ch.is_started        = started_reg;
    assign report_ch.is_paused         = paused_reg;
    assign report_ch.current_rate      = rate_reg;
    assign report_ch.reanchored        = reanch_reg;

endmodule

[rtl/media_presentation_clock.sv]
// path: a command word passes the input, state and result registers in turn
// throughput: one command word per cycle while result words are not stalled;
//   it is set by the state loop: 48 by 20 scaler, saturating add, jump compare
// reset: rst_n is asynchronous and active low; it returns the clock state, the
//   valid flags and config registers to reset values at once, no clearing pass
module media_presentation_clock #(
    parameter int unsigned POSITION_BITS      = mpc_pkg::POSITION_BITS_DEF,
    parameter int unsigned RATE_FRACTION_BITS = mpc_pkg::RATE_FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mpc_cmd_if.sink                         cmd_ch,
    mpc_report_if.source                    report_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [mpc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [mpc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    mpc_pkg::cfg_t                   cfg;
    mpc_pkg::status_t                status;
    logic signed [POSITION_BITS-1:0] clock_pos;
    logic [mpc_pkg::RATE_W-1:0]      rate;
    logic                            report_ready;

    // configuration registers
    mpc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register and clock state
    mpc_clock_core #(
        .POSITION_BITS      (POSITION_BITS),
        .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_ch       (cmd_ch),
        .cfg          (cfg),
        .report_ready (report_ready),
        .status       (status),
        .clock_pos    (clock_pos),
        .rate         (rate)
    );

    // result register
    mpc_report #(
        .POSITION_BITS (POSITION_BITS)
    ) u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .clock_pos    (clock_pos),
        .rate         (rate),
        .sink_latency (cfg.sink_latency),
        .ready        (report_ready),
        .report_ch    (report_ch)
    );

endmodule

[rtl/mpc_chk.sv]
`include "media_presentation_clock_defines.svh"

module mpc_chk (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic report_valid,
    input logic report_ready,
    input logic reanchored,
    input logic is_started,
    input logic pready
);

    // commands stall only behind a stalled result word
    `MPC_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !cmd_ready, report_valid && !report_ready)

    // a re-anchor can only be reported on a started clock
    `MPC_ASSERT_IMPLY(a_reanch_started, clk, rst_n, report_valid && reanchored, is_started)

    // configuration port never waits
    `MPC_ASSERT_IMPLY(a_pready_high, clk, rst_n, cmd_valid || !cmd_valid, pready)

    // a stalled result word stays offered
    `MPC_ASSERT_NEXT(a_report_hold, clk, rst_n, report_valid && !report_ready, report_valid)

endmodule

bind media_presentation_clock mpc_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_ch.valid),
    .cmd_ready    (cmd_ch.ready),
    .report_valid (report_ch.valid),
    .report_ready (report_ch.ready),
    .reanchored   (report_ch.reanchored),
    .is_started   (report_ch.is_started),
    .pready       (pready)
);
